@@ rtl/core/mmts_pkg.sv @@
// Shared types, constants and duty arithmetic for the motor move task sequencer.
// No dependencies; every other file of the block but mmts_fifo imports this package.
`timescale 1ns / 1ps

package mmts_pkg;

    // Task queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);
    localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

    // Input item kinds
    localparam logic [2:0] KIND_TICK    = 3'd0;
    localparam logic [2:0] KIND_ENQ     = 3'd1;
    localparam logic [2:0] KIND_ENQ_ADV = 3'd2;
    localparam logic [2:0] KIND_ENC1    = 3'd3;
    localparam logic [2:0] KIND_ENC2    = 3'd4;
    localparam logic [2:0] KIND_MOVE    = 3'd5;
    localparam logic [2:0] KIND_STOP    = 3'd6;

    // Internal command opcodes, produced by the front end
    typedef logic [2:0] t_op;
    localparam t_op OP_TICK  = 3'd0;
    localparam t_op OP_ENQ   = 3'd1;
    localparam t_op OP_PULSE = 3'd2;
    localparam t_op OP_MOVE  = 3'd3;
    localparam t_op OP_STOP  = 3'd4;
    localparam t_op OP_NOP   = 3'd5;

    // Arithmetic constants
    localparam logic [11:0] DUTY_MAX      = 12'd4095;
    localparam logic [16:0] TICK_MAX      = 17'h1FFFF;
    localparam logic [24:0] ENC_MAX       = 25'h1FFFFFF;
    localparam logic [7:0]  SPEED_FULL    = 8'd127;
    // floor(x/127) = floor(x*DIV127_RECIP >> 38) or one less, for x < 2^31
    localparam logic [31:0] DIV127_RECIP  = 32'd2164392968;
    localparam int          DIV127_SHIFT  = 38;
    // floor(y/127) = (y*DUTY_RECIP) >> 19 exactly for y < 5518
    localparam logic [12:0] DUTY_RECIP    = 13'd4129;
    localparam int          DUTY_SHIFT    = 19;

    typedef struct packed {
        logic [2:0]         kind;
        logic               task_is_distance;
        logic signed [7:0]  motor_1_speed;
        logic signed [7:0]  motor_2_speed;
        logic [15:0]        amount;
    } t_item;

    typedef struct packed {
        logic [11:0]        duty_1a;
        logic [11:0]        duty_1b;
        logic [11:0]        duty_2a;
        logic [11:0]        duty_2b;
        logic               running;
        logic               running_is_distance;
        logic [QC_W-1:0]    queue_count;
        logic               queue_overflow;
        logic               task_advanced;
    } t_result;

    // sel: advance after enqueue, or encoder two for a pulse
    typedef struct packed {
        t_op                op;
        logic               sel;
        logic               is_dist;
        logic [7:0]         s1;
        logic [7:0]         s2;
        logic [15:0]        amount;
    } t_cmd;

    typedef struct packed {
        logic               is_dist;
        logic [7:0]         s1;
        logic [7:0]         s2;
        logic [15:0]        amount;
    } t_task;

    typedef struct packed {
        logic [11:0]        d1a;
        logic [11:0]        d1b;
        logic [11:0]        d2a;
        logic [11:0]        d2b;
    } t_duty;

    // |s| of a two's complement speed, -128 gives 128
    function automatic logic [7:0] speed_mag(input logic [7:0] s);
        return s[7] ? 8'(~s + 8'd1) : s;
    endfunction

    // min(floor(4095*m/127), 4095) as 32*m + floor(31*m/127)
    function automatic logic [11:0] duty_of(input logic [7:0] mag);
        logic [11:0] y;
        logic [24:0] p;
        logic [12:0] d;
        y = 12'({4'd0, mag} * 12'd31);
        p = 25'(y) * 25'(DUTY_RECIP);
        d = {mag, 5'd0} + 13'(p >> DUTY_SHIFT);
        return (d > 13'(DUTY_MAX)) ? DUTY_MAX : d[11:0];
    endfunction

    // H-bridge sides; motor one is wired inverted
    function automatic t_duty drive(input logic [7:0] s1, input logic [7:0] s2);
        logic [11:0] d1;
        logic [11:0] d2;
        t_duty       r;
        d1    = duty_of(speed_mag(s1));
        d2    = duty_of(speed_mag(s2));
        r.d1a = s1[7] ? d1 : 12'd0;
        r.d1b = s1[7] ? 12'd0 : d1;
        r.d2a = s2[7] ? 12'd0 : d2;
        r.d2b = s2[7] ? d2 : 12'd0;
        return r;
    endfunction

endpackage

@@ rtl/core/motor_move_task_sequencer_core.sv @@
// Top level of the two-motor move task sequencer.
// Depends on mmts_pkg, mmts_fifo, mmts_front and mmts_back.
//
//  Channel   | Direction | Handshake              | Beat
//  ----------+-----------+------------------------+---------------------------
//  item      | in        | push / full            | i_item (t_item)
//  result    | out       | empty / pop            | o_res (t_result)
//  config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (encoder scale)
//
// Each item gives one result beat. In the back end an item that causes no advance
// passes the idle, execute and done states; an advance that finds the queue empty adds
// the advance state, and one that loads a task adds the load states, which cover the
// registered task memory read and the three multiply stages of the distance target.
// A two-entry command queue and a two-entry result queue let each side stall alone.
// Reset is synchronous: queues, counters, duties clear; the encoder scale returns to 1.
`timescale 1ns / 1ps

module motor_move_task_sequencer_core
    import mmts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    input  t_item      i_item,
    output logic       full,
    output t_result    o_res,
    output logic       empty,
    input  logic       pop,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    t_cmd    w_cmd;
    logic    w_cmd_valid;
    logic    w_cmd_pop;
    logic    w_res_full;
    logic    w_res_push;
    t_result w_res;

    mmts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    mmts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue toward the consumer
    mmts_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_res)
    );

endmodule

@@ rtl/core/mmts_fifo.sv @@
// Small flip-flop queue used between the block's sections.
// Depends on nothing; width and depth come from the instantiating module.
`timescale 1ns / 1ps

module mmts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_data[r_rptr];

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/mmts_front.sv @@
// Front end: takes input beats, decodes the item kind into a command and queues it.
// Depends on mmts_pkg and mmts_fifo.
`timescale 1ns / 1ps

module mmts_front
    import mmts_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output t_cmd  o_cmd,
    output logic  o_cmd_valid,
    input  logic  i_cmd_pop
);

    t_cmd w_cmd;
    logic w_empty;

    // classify the kind
    always_comb begin
        w_cmd.sel     = 1'b0;
        w_cmd.is_dist = i_item.task_is_distance;
        w_cmd.s1      = i_item.motor_1_speed;
        w_cmd.s2      = i_item.motor_2_speed;
        w_cmd.amount  = i_item.amount;
        unique case (i_item.kind)
            KIND_TICK:    w_cmd.op = OP_TICK;
            KIND_ENQ:     w_cmd.op = OP_ENQ;
            KIND_ENQ_ADV: begin
                w_cmd.op  = OP_ENQ;
                w_cmd.sel = 1'b1;
            end
            KIND_ENC1:    w_cmd.op = OP_PULSE;
            KIND_ENC2:    begin
                w_cmd.op  = OP_PULSE;
                w_cmd.sel = 1'b1;
            end
            KIND_MOVE:    w_cmd.op = OP_MOVE;
            KIND_STOP:    w_cmd.op = OP_STOP;
            default:      w_cmd.op = OP_NOP;
        endcase
    end

    // command queue toward the back end
    mmts_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd),
        .o_full  (o_full),
        .o_empty (w_empty),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd)
    );

    assign o_cmd_valid = !w_empty;

endmodule

@@ rtl/core/mmts_back.sv @@
// Back end: task queue memory, running-task state, distance target pipeline, duties.
// Depends on mmts_pkg; fed by mmts_front, drains into the result queue.
`timescale 1ns / 1ps

module mmts_back
    import mmts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_cmd_valid,
    output logic       o_cmd_pop,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_res_full,
    output logic       o_res_push,
    output t_result    o_res
);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_ADV  = 3'd2;
    localparam logic [2:0] S_LD0  = 3'd3;
    localparam logic [2:0] S_LD1  = 3'd4;
    localparam logic [2:0] S_LD2  = 3'd5;
    localparam logic [2:0] S_LD3  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    t_cmd            r_cmd;
    logic [QA_W-1:0] r_head;
    logic [QC_W-1:0] r_fill;
    logic            r_running;
    logic            r_cur_dist;
    logic [15:0]     r_cur_amount;
    logic [16:0]     r_elapsed;
    logic [24:0]     r_enc1;
    logic [24:0]     r_enc2;
    logic [24:0]     r_tgt1;
    logic [24:0]     r_tgt2;
    t_duty           r_duty;
    logic            r_ovf;
    logic            r_adv;
    logic [7:0]      r_coef;
    t_task           r_mem [QUEUE_DEPTH];
    t_task           r_rd_data;
    logic [23:0]     r_pa1;
    logic [23:0]     r_pa2;
    logic [30:0]     r_pb1;
    logic [30:0]     r_pb2;
    logic [24:0]     r_q1;
    logic [24:0]     r_q2;

    logic [QA_W-1:0] w_head_inc;
    logic [QA_W:0]   w_wr_sum;
    logic [QA_W-1:0] w_wr_addr;
    logic [QA_W-1:0] w_rd_addr;
    logic [QC_W-1:0] w_fill_pop;
    logic            w_q_full;
    logic            w_mem_we;
    t_task           w_new_task;
    logic [16:0]     w_tick_inc;
    logic            w_tick_hit;
    logic [24:0]     w_enc_cur;
    logic [24:0]     w_enc_inc;
    logic [24:0]     w_enc_tgt;
    logic            w_enc_hit;
    logic            w_go_adv;
    logic [24:0]     w_q1;
    logic [24:0]     w_q2;
    logic [31:0]     w_r1;
    logic [31:0]     w_r2;
    logic [24:0]     w_t1;
    logic [24:0]     w_t2;

    assign o_cfg_ready = 1'b1;
    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && !i_res_full;
    assign o_res_push  = (r_state == S_DONE);

    // queue addressing
    assign w_head_inc = (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign w_wr_sum   = {1'b0, r_head} + (QA_W + 1)'(r_fill);
    assign w_wr_addr  = (w_wr_sum >= (QA_W + 1)'(QUEUE_DEPTH))
                      ? QA_W'(w_wr_sum - (QA_W + 1)'(QUEUE_DEPTH)) : QA_W'(w_wr_sum);
    assign w_rd_addr  = r_running ? w_head_inc : r_head;
    assign w_fill_pop = r_running ? r_fill - 1'b1 : r_fill;
    assign w_q_full   = (r_fill == QC_W'(QUEUE_DEPTH));
    assign w_mem_we   = (r_state == S_EXEC) && (r_cmd.op == OP_ENQ) && !w_q_full;

    assign w_new_task.is_dist = r_cmd.is_dist;
    assign w_new_task.s1      = r_cmd.s1;
    assign w_new_task.s2      = r_cmd.s2;
    assign w_new_task.amount  = r_cmd.amount;

    // tick and encoder end conditions
    assign w_tick_inc = (r_elapsed == TICK_MAX) ? r_elapsed : r_elapsed + 1'b1;
    assign w_tick_hit = r_running && !r_cur_dist && (w_tick_inc >= {1'b0, r_cur_amount});
    assign w_enc_cur  = r_cmd.sel ? r_enc2 : r_enc1;
    assign w_enc_tgt  = r_cmd.sel ? r_tgt2 : r_tgt1;
    assign w_enc_inc  = (w_enc_cur == ENC_MAX) ? w_enc_cur : w_enc_cur + 1'b1;
    assign w_enc_hit  = r_running && r_cur_dist && (w_enc_inc >= w_enc_tgt);

    always_comb begin
        unique case (r_cmd.op)
            OP_TICK:  w_go_adv = w_tick_hit;
            OP_ENQ:   w_go_adv = r_cmd.sel;
            OP_PULSE: w_go_adv = w_enc_hit;
            default:  w_go_adv = 1'b0;
        endcase
    end

    // divide by 127: reciprocal estimate, then one remainder correction
    assign w_q1 = 25'((63'(r_pb1) * 63'(DIV127_RECIP)) >> DIV127_SHIFT);
    assign w_q2 = 25'((63'(r_pb2) * 63'(DIV127_RECIP)) >> DIV127_SHIFT);
    assign w_r1 = 32'(r_pb1) - {r_q1, 7'd0} + 32'(r_q1);
    assign w_r2 = 32'(r_pb2) - {r_q2, 7'd0} + 32'(r_q2);
    assign w_t1 = (w_r1 >= 32'(SPEED_FULL)) ? 25'(r_q1) + 1'b1 : 25'(r_q1);
    assign w_t2 = (w_r2 >= 32'(SPEED_FULL)) ? 25'(r_q2) + 1'b1 : 25'(r_q2);

    // next state
    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = o_cmd_pop ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = w_go_adv ? S_ADV : S_DONE;
            S_ADV:   n_state = (w_fill_pop == '0) ? S_DONE : S_LD0;
            S_LD0:   n_state = S_LD1;
            S_LD1:   n_state = S_LD2;
            S_LD2:   n_state = S_LD3;
            S_LD3:   n_state = S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    // control and task state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_fill     <= '0;
            r_running  <= 1'b0;
            r_cur_dist <= 1'b0;
            r_elapsed  <= '0;
            r_enc1     <= '0;
            r_enc2     <= '0;
            r_tgt1     <= '0;
            r_tgt2     <= '0;
            r_duty     <= '0;
            r_ovf      <= 1'b0;
            r_adv      <= 1'b0;
            r_coef     <= 8'd1;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_coef <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_ovf <= 1'b0;
                        r_adv <= 1'b0;
                    end
                end
                S_EXEC: begin
                    r_adv <= w_go_adv;
                    unique case (r_cmd.op)
                        OP_TICK: begin
                            if (r_running && !r_cur_dist) begin
                                r_elapsed <= w_tick_inc;
                            end
                        end
                        OP_ENQ: begin
                            if (w_q_full) begin
                                r_ovf <= 1'b1;
                            end else begin
                                r_fill <= r_fill + 1'b1;
                            end
                        end
                        OP_PULSE: begin
                            if (r_running && r_cur_dist) begin
                                if (r_cmd.sel) begin
                                    r_enc2 <= w_enc_inc;
                                end else begin
                                    r_enc1 <= w_enc_inc;
                                end
                            end
                        end
                        OP_MOVE: begin
                            if (r_running) begin
                                r_head    <= w_head_inc;
                                r_fill    <= r_fill - 1'b1;
                                r_running <= 1'b0;
                            end
                            r_duty <= drive(r_cmd.s1, r_cmd.s2);
                        end
                        OP_STOP: begin
                            if (r_fill != '0) begin
                                r_head <= w_head_inc;
                                r_fill <= r_fill - 1'b1;
                            end
                            r_running <= 1'b0;
                            r_duty    <= '0;
                        end
                        default: ;
                    endcase
                end
                S_ADV: begin
                    // pop the finished task, if one runs; the new head is read this cycle
                    r_head <= w_rd_addr;
                    r_fill <= w_fill_pop;
                    if (w_fill_pop == '0) begin
                        r_running <= 1'b0;
                        r_duty    <= '0;
                    end
                end
                S_LD0: begin
                    r_running  <= 1'b1;
                    r_cur_dist <= r_rd_data.is_dist;
                    r_elapsed  <= '0;
                    r_enc1     <= '0;
                    r_enc2     <= '0;
                    r_duty     <= drive(r_rd_data.s1, r_rd_data.s2);
                end
                S_LD3: begin
                    r_tgt1 <= w_t1;
                    r_tgt2 <= w_t2;
                end
                default: ;
            endcase
        end
    end

    // command and target pipeline payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_LD0) begin
            r_cur_amount <= r_rd_data.amount;
            r_pa1        <= 24'(r_rd_data.amount) * 24'(speed_mag(r_rd_data.s1));
            r_pa2        <= 24'(r_rd_data.amount) * 24'(speed_mag(r_rd_data.s2));
        end
        if (r_state == S_LD1) begin
            r_pb1 <= 31'(r_pa1) * 31'(r_coef);
            r_pb2 <= 31'(r_pa2) * 31'(r_coef);
        end
        if (r_state == S_LD2) begin
            r_q1 <= w_q1;
            r_q2 <= w_q2;
        end
    end

    // task queue memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_wr_addr] <= w_new_task;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // status beat
    assign o_res.duty_1a             = r_duty.d1a;
    assign o_res.duty_1b             = r_duty.d1b;
    assign o_res.duty_2a             = r_duty.d2a;
    assign o_res.duty_2b             = r_duty.d2b;
    assign o_res.running             = r_running;
    assign o_res.running_is_distance = r_running && r_cur_dist;
    assign o_res.queue_count         = r_fill;
    assign o_res.queue_overflow      = r_ovf;
    assign o_res.task_advanced       = r_adv;

endmodule

@@ rtl/core/mmts_checker.sv @@
// Port-level checks for the move task sequencer, bound to the top level.
// Depends on mmts_pkg and motor_move_task_sequencer_core.
`timescale 1ns / 1ps

module mmts_checker
    import mmts_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    full,
    input  t_result o_res,
    input  logic    empty,
    input  logic    pop
);

    // reset leaves both queues drained
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not cleared by reset");

    // a running task sits in the queue
    a_running_has_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.running |-> o_res.queue_count != '0)
        else $error("running with an empty task queue");

    // distance flag only while a task runs
    a_dist_needs_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.running_is_distance |-> o_res.running)
        else $error("distance flag without running task");

    // overflow only with a full queue, less the head an advance may have popped
    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_res.queue_overflow |->
            o_res.queue_count >= QC_W'(QUEUE_DEPTH - 1))
        else $error("overflow reported with room in the queue");

    // a waiting result beat holds until taken
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_res))
        else $error("result beat changed while stalled");

endmodule

bind motor_move_task_sequencer_core mmts_checker u_mmts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .o_res   (o_res),
    .empty   (empty),
    .pop     (pop)
);

@@ bench/tb_top.sv @@
// Self-checking bench for the two-motor move task sequencer core.
// Depends on mmts_pkg and motor_move_task_sequencer_core; predicts every status beat
// from its own model of the task queue, duty law and counters.
`timescale 1ns / 1ps

module tb_top;
    import mmts_pkg::*;

    localparam logic [2:0] KIND_SPARE  = 3'd7;   // unused kind, only reports status
    localparam int         STALL_LIMIT = 3000;   // cycles without any beat
    localparam int         HALF_PHASE  = 100;    // at least this many random items per half phase

    // DUT hookup
    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    t_item      i_item      = '0;
    logic       full;
    t_result    o_res;
    logic       empty;
    logic       pop         = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = 8'd0;

    motor_move_task_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .o_res       (o_res),
        .empty       (empty),
        .pop         (pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Bench bookkeeping
    t_item   move_items[$];          // items waiting to be driven
    t_result status_due[$];          // predicted status beats, oldest first
    int      items_queued   = 0;
    int      items_taken    = 0;
    int      results_seen   = 0;
    int      fault_count    = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      stall_cycles   = 0;
    logic    item_fire      = 1'b0;

    // Sequencer model state
    typedef struct packed {
        logic        by_dist;
        logic [7:0]  s1;
        logic [7:0]  s2;
        logic [15:0] amt;
    } move_task_t;

    move_task_t  mv_mem [QUEUE_DEPTH];
    int          mv_head      = 0;
    int          mv_fill      = 0;
    logic        mv_run       = 1'b0;
    logic [16:0] mv_ticks     = '0;
    logic [24:0] enc_cnt [2]  = '{default: '0};
    logic [24:0] enc_tgt [2]  = '{default: '0};
    logic [11:0] duty_q [4]   = '{default: '0};
    logic [7:0]  enc_scale_m  = 8'd1;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic log_fault(input string msg);
        $display("[%0t] %s", $time, msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            log_fault($sformatf("status %0d: %s = %0d, predicted %0d",
                                results_seen, name, got, want));
    endtask

    // |s| of a raw speed; -128 gives 128
    function automatic logic [7:0] abs_speed(input logic [7:0] s);
        return s[7] ? 8'(-s) : s;
    endfunction

    function automatic logic [11:0] bridge_duty(input logic [7:0] m);
        int unsigned d;
        d = 4095 * m / 127;
        return (d > 4095) ? 12'd4095 : 12'(d);
    endfunction

    // motor one is wired inverted: negative speed drives side A
    function automatic void set_bridge(input logic [7:0] s1, input logic [7:0] s2);
        logic [11:0] d1;
        logic [11:0] d2;
        d1 = bridge_duty(abs_speed(s1));
        d2 = bridge_duty(abs_speed(s2));
        duty_q[0] = s1[7] ? d1 : 12'd0;
        duty_q[1] = s1[7] ? 12'd0 : d1;
        duty_q[2] = s2[7] ? 12'd0 : d2;
        duty_q[3] = s2[7] ? d2 : 12'd0;
    endfunction

    function automatic logic [24:0] pulse_goal(input logic [15:0] amt,
                                               input logic [7:0] s);
        longint unsigned p;
        p = amt;
        p = p * abs_speed(s) * enc_scale_m;
        return 25'(p / 127);
    endfunction

    function automatic logic head_dist();
        return mv_run && mv_fill > 0 && mv_mem[mv_head].by_dist;
    endfunction

    function automatic void drop_head();
        if (mv_fill > 0) begin
            mv_head = (mv_head + 1) % QUEUE_DEPTH;
            mv_fill--;
        end
    endfunction

    // Retire the running task and start the next one, if any
    function automatic void load_next();
        move_task_t h;
        if (mv_run)
            drop_head();
        if (mv_fill == 0) begin
            mv_run = 1'b0;
            duty_q = '{default: '0};
            return;
        end
        h          = mv_mem[mv_head];
        mv_run     = 1'b1;
        mv_ticks   = '0;
        enc_cnt[0] = '0;
        enc_cnt[1] = '0;
        if (h.by_dist) begin
            enc_tgt[0] = pulse_goal(h.amt, h.s1);
            enc_tgt[1] = pulse_goal(h.amt, h.s2);
        end
        set_bridge(h.s1, h.s2);
    endfunction

    // Apply one item to the model and return the status it should report
    function automatic t_result next_status(input t_item it);
        t_result    r;
        move_task_t t;
        logic       ovf;
        logic       adv;
        int         e;
        ovf = 1'b0;
        adv = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                if (mv_run && mv_fill > 0 && !head_dist()) begin
                    if (mv_ticks != TICK_MAX)
                        mv_ticks++;
                    if (mv_ticks >= mv_mem[mv_head].amt) begin
                        load_next();
                        adv = 1'b1;
                    end
                end
            end
            KIND_ENQ, KIND_ENQ_ADV: begin
                if (mv_fill >= QUEUE_DEPTH) begin
                    ovf = 1'b1;
                end else begin
                    t.by_dist = it.task_is_distance;
                    t.s1      = it.motor_1_speed;
                    t.s2      = it.motor_2_speed;
                    t.amt     = it.amount;
                    mv_mem[(mv_head + mv_fill) % QUEUE_DEPTH] = t;
                    mv_fill++;
                end
                // a dropped enqueue still advances
                if (it.kind == KIND_ENQ_ADV) begin
                    load_next();
                    adv = 1'b1;
                end
            end
            KIND_ENC1, KIND_ENC2: begin
                if (head_dist()) begin
                    e = (it.kind == KIND_ENC2) ? 1 : 0;
                    if (enc_cnt[e] != ENC_MAX)
                        enc_cnt[e]++;
                    if (enc_cnt[e] >= enc_tgt[e]) begin
                        load_next();
                        adv = 1'b1;
                    end
                end
            end
            KIND_MOVE: begin
                if (mv_run) begin
                    drop_head();
                    mv_run = 1'b0;
                end
                set_bridge(it.motor_1_speed, it.motor_2_speed);
            end
            KIND_STOP: begin
                drop_head();
                mv_run = 1'b0;
                duty_q = '{default: '0};
            end
            default: ;
        endcase
        r.duty_1a             = duty_q[0];
        r.duty_1b             = duty_q[1];
        r.duty_2a             = duty_q[2];
        r.duty_2b             = duty_q[3];
        r.running             = mv_run;
        r.running_is_distance = head_dist();
        r.queue_count         = QC_W'(mv_fill);
        r.queue_overflow      = ovf;
        r.task_advanced       = adv;
        return r;
    endfunction

    // Item driver: holds a beat until taken, idles at random
    always @(negedge i_clk) begin : feed_items
        logic go;
        if (item_fire)
            void'(move_items.pop_front());
        if (!(push && !item_fire)) begin
            go = i_rst_n && move_items.size() != 0 &&
                 $urandom_range(1, 100) > send_idle_pct;
            push <= go;
            if (go)
                i_item <= move_items[0];
        end
        pop <= i_rst_n && ($urandom_range(1, 100) > recv_stall_pct);
    end

    // Monitor: predict on item beats, check status beats, track config
    always @(posedge i_clk) begin : watch_beats
        t_result want;
        item_fire = push && !full;
        if (pop && !empty) begin
            if (status_due.size() == 0) begin
                log_fault($sformatf("status beat after %0d with nothing predicted",
                                    results_seen));
            end else begin
                want = status_due.pop_front();
                check_field("duty_1a", o_res.duty_1a, want.duty_1a);
                check_field("duty_1b", o_res.duty_1b, want.duty_1b);
                check_field("duty_2a", o_res.duty_2a, want.duty_2a);
                check_field("duty_2b", o_res.duty_2b, want.duty_2b);
                check_field("running", o_res.running, want.running);
                check_field("running_is_distance", o_res.running_is_distance,
                            want.running_is_distance);
                check_field("queue_count", o_res.queue_count, want.queue_count);
                check_field("queue_overflow", o_res.queue_overflow, want.queue_overflow);
                check_field("task_advanced", o_res.task_advanced, want.task_advanced);
                results_seen <= results_seen + 1;
            end
        end
        if (item_fire) begin
            status_due.push_back(next_status(i_item));
            items_taken <= items_taken + 1;
        end
        if (i_cfg_valid && o_cfg_ready)
            enc_scale_m = i_cfg_data;
    end

    // Watchdog: any accepted beat on any channel restarts the count
    always @(posedge i_clk) begin : watchdog
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic add_item(input logic [2:0] kind, input logic dist_flag,
                            input logic [7:0] s1, input logic [7:0] s2,
                            input logic [15:0] amt);
        t_item it;
        it.kind             = kind;
        it.task_is_distance = dist_flag;
        it.motor_1_speed    = s1;
        it.motor_2_speed    = s2;
        it.amount           = amt;
        move_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [7:0] rand_speed();
        case ($urandom_range(0, 5))
            0:       return 8'h80;
            1:       return 8'h7F;
            2:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly short tasks so ticks and pulses finish them
    function automatic logic [15:0] task_amount();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 16'($urandom_range(0, 4));
        if (r < 9)
            return 16'($urandom_range(5, 40));
        return 16'($urandom);
    endfunction

    function automatic logic [2:0] rand_event();
        case ($urandom_range(0, 3))
            0:       return KIND_ENC1;
            1:       return KIND_ENC2;
            default: return KIND_TICK;
        endcase
    endfunction

    task automatic add_event();
        add_item(rand_event(), 1'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    endtask

    task automatic fill_random(input int n);
        int stop_at;
        int sel;
        stop_at = items_queued + n;
        while (items_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                // program: queue a few tasks, start, then feed ticks and pulses
                repeat ($urandom_range(0, 4))
                    add_item(KIND_ENQ, 1'($urandom), rand_speed(), rand_speed(),
                             task_amount());
                add_item(KIND_ENQ_ADV, 1'($urandom), rand_speed(), rand_speed(),
                         task_amount());
                repeat ($urandom_range(2, 24))
                    add_event();
            end else if (sel < 55) begin
                // enqueue burst, usually runs into a full queue
                repeat ($urandom_range(12, 20))
                    add_item(KIND_ENQ, 1'($urandom), rand_speed(), rand_speed(),
                             task_amount());
            end else if (sel < 70) begin
                repeat ($urandom_range(1, 10))
                    add_event();
            end else if (sel < 80) begin
                add_item($urandom_range(0, 1) ? KIND_MOVE : KIND_STOP, 1'($urandom),
                         rand_speed(), rand_speed(), 16'($urandom));
            end else begin
                add_item(3'($urandom_range(0, 7)), 1'($urandom), 8'($urandom),
                         8'($urandom), 16'($urandom));
            end
        end
    endtask

    // wait until every queued item has been taken and its status checked
    task automatic wait_idle();
        while (items_taken != items_queued || results_seen != items_queued)
            @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Test sequence
    initial begin : run_test
        logic [7:0] coef_plan [8];
        coef_plan = '{8'd1, 8'd0, 8'd255, 8'd0, 8'd2, 8'd255, 8'd0, 8'd1};
        coef_plan[3] = 8'($urandom_range(3, 254));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every kind, zero targets, inverted motor one
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);      // nothing running
        add_item(KIND_ENC1, 1'b0, 8'h00, 8'h00, 16'd0);      // pulse ignored
        add_item(KIND_MOVE, 1'b0, 8'h80, 8'h7F, 16'd0);      // -128 saturates
        add_item(KIND_MOVE, 1'b0, 8'h7F, 8'h80, 16'd0);
        add_item(KIND_MOVE, 1'b0, 8'h81, 8'h01, 16'd0);
        add_item(KIND_STOP, 1'b0, 8'h00, 8'h00, 16'd0);      // stop on empty queue
        add_item(KIND_ENQ, 1'b0, 8'hFF, 8'h01, 16'd0);       // timed, zero length
        add_item(KIND_ENQ, 1'b1, 8'h7F, 8'h81, 16'd0);       // distance, zero target
        add_item(KIND_ENQ, 1'b0, 8'h40, 8'hC0, 16'hFFFF);
        add_item(KIND_ENQ_ADV, 1'b0, 8'h00, 8'h00, 16'd2);
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);      // ends on first tick
        add_item(KIND_ENC2, 1'b0, 8'h00, 8'h00, 16'd0);      // ends on first pulse
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);
        add_item(KIND_ENC1, 1'b0, 8'h00, 8'h00, 16'd0);      // timed task: ignored
        add_item(KIND_MOVE, 1'b0, 8'h05, 8'hFB, 16'd0);      // pops the running task
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);
        add_item(KIND_ENQ_ADV, 1'b1, 8'h7F, 8'h7F, 16'd1);   // start without a pop
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);
        add_item(KIND_TICK, 1'b0, 8'h00, 8'h00, 16'd0);
        add_item(KIND_ENC1, 1'b0, 8'h00, 8'h00, 16'd0);      // queue runs dry
        add_item(KIND_SPARE, 1'b1, 8'hFF, 8'hFF, 16'hFFFF);
        add_item(KIND_STOP, 1'b0, 8'h00, 8'h00, 16'd0);
        wait_idle();

        // Random phases: coefficient settings crossed with idle patterns
        for (int p = 0; p < 8; p++) begin
            if (p > 0)
                write_coef(coef_plan[p]);
            send_idle_pct  = (p % 4 == 1) ? 51 : (p % 4 == 3) ? 37 : 0;
            recv_stall_pct = (p % 4 == 2) ? 51 : (p % 4 == 3) ? 37 : 0;
            fill_random(HALF_PHASE);
            wait_idle();    // sender holds off until every status is back
            fill_random(HALF_PHASE);
            wait_idle();
        end

        // drain margin; any stray beat is flagged by the monitor
        repeat (16) @(posedge i_clk);
        if (status_due.size() != 0)
            log_fault($sformatf("%0d predicted status beats never arrived",
                                status_due.size()));
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
